FILE: design/lrs_pkg.sv
// Package for the link reconnect supervisor: widths, reset values and the
// shared struct types for configuration, poll items, results and state.
// No dependencies; every other design file imports it.
package lrs_pkg;

    localparam int TIME_W  = 32;
    localparam int COUNT_W = 32;
    localparam int CYCLE_W = 4;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 136;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_RETRY_INTERVAL  = 2'd0;
    localparam logic [IDX_W-1:0] REG_ATTEMPT_TIMEOUT = 2'd1;
    localparam logic [IDX_W-1:0] REG_COOLDOWN        = 2'd2;
    localparam logic [IDX_W-1:0] REG_MAX_ATTEMPTS    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [TIME_W-1:0]  RETRY_INTERVAL_RST  = 32'd10000;
    localparam logic [TIME_W-1:0]  ATTEMPT_TIMEOUT_RST = 32'd15000;
    localparam logic [TIME_W-1:0]  COOLDOWN_RST        = 32'd30000;
    localparam logic [CYCLE_W-1:0] MAX_ATTEMPTS_RST    = 4'd5;

    typedef struct packed {
        logic [TIME_W-1:0]  retry_interval_ms;
        logic [TIME_W-1:0]  attempt_timeout_ms;
        logic [TIME_W-1:0]  cooldown_ms;
        logic [CYCLE_W-1:0] max_attempts;
    } lrs_cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              link_up;
        logic              creds_configured;
        logic              ssid_present;
        logic              event_ack;
    } lrs_poll_t;

    typedef struct packed {
        logic               was_up;
        logic               attempt_pending;
        logic               cooldown_active;
        logic               event_flag;
        logic [CYCLE_W-1:0] cycle_attempts;
        logic [TIME_W-1:0]  last_attempt_time;
        logic [TIME_W-1:0]  attempt_start_time;
        logic [TIME_W-1:0]  cooldown_start_time;
        logic [COUNT_W-1:0] disconnect_counter;
        logic [COUNT_W-1:0] attempt_counter;
        logic [COUNT_W-1:0] success_counter;
        logic [COUNT_W-1:0] failure_counter;
    } lrs_state_t;

    typedef struct packed {
        logic               connected;
        logic               start_reconnect;
        logic               recovery_event;
        logic [CYCLE_W-1:0] attempt_in_cycle;
        logic               in_cooldown;
        logic [COUNT_W-1:0] disconnect_total;
        logic [COUNT_W-1:0] attempt_total;
        logic [COUNT_W-1:0] success_total;
        logic [COUNT_W-1:0] failure_total;
    } lrs_result_t;

endpackage

FILE: design/lrs_cfg.sv
// Configuration register file of the link reconnect supervisor.
// Decodes the plain write port into the four timing and limit registers.
// Depends on lrs_pkg.
module lrs_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [lrs_pkg::IDX_W-1:0]   cfg_index,
    input  logic [lrs_pkg::CFG_W-1:0]   cfg_wdata,
    output lrs_pkg::lrs_cfg_t           cfg
);
    import lrs_pkg::*;

    lrs_cfg_t cfg_reg;
    lrs_cfg_t cfg_next;

    // Write decode; bits above a register's width are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RETRY_INTERVAL:  cfg_next.retry_interval_ms  = cfg_wdata;
                REG_ATTEMPT_TIMEOUT: cfg_next.attempt_timeout_ms = cfg_wdata;
                REG_COOLDOWN:        cfg_next.cooldown_ms        = cfg_wdata;
                REG_MAX_ATTEMPTS:    cfg_next.max_attempts       = cfg_wdata[CYCLE_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.retry_interval_ms  <= RETRY_INTERVAL_RST;
            cfg_reg.attempt_timeout_ms <= ATTEMPT_TIMEOUT_RST;
            cfg_reg.cooldown_ms        <= COOLDOWN_RST;
            cfg_reg.max_attempts       <= MAX_ATTEMPTS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/lrs_step.sv
// Poll update logic of the link reconnect supervisor: from one poll item,
// the configuration and the current state it forms the next state and result.
// Purely combinational; depends on lrs_pkg.
module lrs_step (
    input  lrs_pkg::lrs_cfg_t    cfg,
    input  lrs_pkg::lrs_poll_t   poll,
    input  lrs_pkg::lrs_state_t  state,
    output lrs_pkg::lrs_state_t  state_next,
    output lrs_pkg::lrs_result_t result
);
    import lrs_pkg::*;

    logic [TIME_W-1:0] pending_age;
    logic [TIME_W-1:0] cooldown_age;
    logic [TIME_W-1:0] retry_age;
    logic              timed_out;
    logic              cooldown_running;
    logic              interval_open;

    // Wrapping ages against the three stored timestamps.
    assign pending_age      = poll.now_ms - state.attempt_start_time;
    assign cooldown_age     = poll.now_ms - state.cooldown_start_time;
    assign retry_age        = poll.now_ms - state.last_attempt_time;
    assign timed_out        = pending_age >= cfg.attempt_timeout_ms;
    assign cooldown_running = cooldown_age < cfg.cooldown_ms;
    assign interval_open    = retry_age >= cfg.retry_interval_ms;

    logic [CYCLE_W-1:0] cycle_now;
    logic               start;

    always_comb begin
        state_next = state;
        start      = 1'b0;
        cycle_now  = state.cycle_attempts;

        // The acknowledge clears the event before anything else.
        if (poll.event_ack) begin
            state_next.event_flag = 1'b0;
        end

        if (poll.link_up) begin
            // Rising edge: new cycle, a pending attempt counts as a success.
            if (!state.was_up) begin
                state_next.was_up          = 1'b1;
                state_next.cycle_attempts  = '0;
                state_next.cooldown_active = 1'b0;
                if (state.attempt_pending) begin
                    state_next.attempt_pending = 1'b0;
                    state_next.success_counter = state.success_counter + 1'b1;
                    state_next.event_flag      = 1'b1;
                end
            end
        end else begin
            // Falling edge of the link.
            if (state.was_up) begin
                state_next.was_up             = 1'b0;
                state_next.disconnect_counter = state.disconnect_counter + 1'b1;
            end
            // Pending attempt that reached its timeout fails.
            if (state.attempt_pending && timed_out) begin
                state_next.attempt_pending = 1'b0;
                state_next.failure_counter = state.failure_counter + 1'b1;
            end
            // Retry scheduling, only with credentials and outside a running cooldown.
            if (poll.creds_configured && !(state.cooldown_active && cooldown_running)) begin
                if (state.cooldown_active) begin
                    state_next.cooldown_active = 1'b0;
                    state_next.cycle_attempts  = '0;
                    cycle_now                  = '0;
                end
                if (interval_open) begin
                    if (cycle_now >= cfg.max_attempts) begin
                        state_next.cooldown_active     = 1'b1;
                        state_next.cooldown_start_time = poll.now_ms;
                    end else if (poll.ssid_present) begin
                        state_next.cycle_attempts     = cycle_now + 1'b1;
                        state_next.attempt_counter    = state.attempt_counter + 1'b1;
                        state_next.last_attempt_time  = poll.now_ms;
                        state_next.attempt_start_time = poll.now_ms;
                        state_next.attempt_pending    = 1'b1;
                        start                         = 1'b1;
                    end
                end
            end
        end
    end

    // Result reflects the state after the update.
    always_comb begin
        result.connected        = poll.link_up;
        result.start_reconnect  = start;
        result.recovery_event   = state_next.event_flag;
        result.attempt_in_cycle = state_next.cycle_attempts;
        result.in_cooldown      = state_next.cooldown_active;
        result.disconnect_total = state_next.disconnect_counter;
        result.attempt_total    = state_next.attempt_counter;
        result.success_total    = state_next.success_counter;
        result.failure_total    = state_next.failure_counter;
    end

endmodule

FILE: design/link_reconnect_supervisor_core.sv
// Top level of the link reconnect supervisor: stream ports, input and result
// registers, supervisor state. Depends on lrs_pkg, lrs_cfg and lrs_step.
//
// Each input item is one poll of the link; exactly one result item comes back
// per poll. The block takes one item per clock while the output side is not
// stalled: an item is accepted into the input register, is evaluated there and
// lands in the result register, from which its result is offered on the master
// side. A stalled result holds the input register and then the input side. The
// supervisor state updates as an item moves into the result register, so the
// next item already sees it. Configuration is written through the plain write
// port; the user must write it only while no item is in flight, as the block
// itself does not enforce this.
module link_reconnect_supervisor_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_wr_en,
    input  logic [lrs_pkg::IDX_W-1:0]     cfg_index,
    input  logic [lrs_pkg::CFG_W-1:0]     cfg_wdata,
    // Poll items.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: now_ms[31:0], link_up[32], creds_configured[33], ssid_present[34],
    // event_ack[35], zero pad [39:36]
    input  logic [lrs_pkg::S_DATA_W-1:0]  s_tdata,
    // Result items.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: connected[0], start_reconnect[1], recovery_event[2],
    // attempt_in_cycle[6:3], in_cooldown[7], disconnect_total[39:8],
    // attempt_total[71:40], success_total[103:72], failure_total[135:104]
    output logic [lrs_pkg::M_DATA_W-1:0]  m_tdata
);
    import lrs_pkg::*;

    lrs_cfg_t    cfg;
    lrs_poll_t   poll_in;
    lrs_poll_t   poll_reg;
    logic        in_valid_reg;
    lrs_state_t  state_reg;
    lrs_state_t  state_next;
    lrs_result_t result;
    lrs_result_t result_reg;
    logic        out_valid_reg;
    logic        advance;

    lrs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Unpack the incoming item.
    assign poll_in.now_ms           = s_tdata[TIME_W-1:0];
    assign poll_in.link_up          = s_tdata[TIME_W];
    assign poll_in.creds_configured = s_tdata[TIME_W+1];
    assign poll_in.ssid_present     = s_tdata[TIME_W+2];
    assign poll_in.event_ack        = s_tdata[TIME_W+3];

    // The held item moves on whenever the result register is free or drains.
    // No item is taken while reset is asserted.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = aresetn && (!in_valid_reg || advance);

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            poll_reg <= poll_in;
        end
    end

    lrs_step u_step (
        .cfg        (cfg),
        .poll       (poll_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Supervisor state, updated once per evaluated item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    // Pack the result item.
    assign m_tvalid          = out_valid_reg;
    assign m_tdata[0]        = result_reg.connected;
    assign m_tdata[1]        = result_reg.start_reconnect;
    assign m_tdata[2]        = result_reg.recovery_event;
    assign m_tdata[6:3]      = result_reg.attempt_in_cycle;
    assign m_tdata[7]        = result_reg.in_cooldown;
    assign m_tdata[39:8]     = result_reg.disconnect_total;
    assign m_tdata[71:40]    = result_reg.attempt_total;
    assign m_tdata[103:72]   = result_reg.success_total;
    assign m_tdata[135:104]  = result_reg.failure_total;

`ifndef SYNTHESIS
    // A reconnect is only commanded while the link is down.
    a_start_when_down: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(result_reg.start_reconnect && result_reg.connected))
        else $error("reconnect commanded while link is up");

    // Starting an attempt and being in cooldown exclude each other.
    a_start_not_cooldown: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(result_reg.start_reconnect && result_reg.in_cooldown))
        else $error("reconnect started during cooldown");

    // A started attempt is counted in the current cycle.
    a_start_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result_reg.start_reconnect) |-> (result_reg.attempt_in_cycle != '0))
        else $error("attempt started with zero cycle count");

    // The state only moves when an item is evaluated.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!advance && $past(aresetn)) |=> $stable(state_reg))
        else $error("state changed without an item");

    // An item is never lost: a full input register with a stalled output holds.
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while stalled item pending");
`endif

endmodule

FILE: verif/link_reconnect_supervisor_core_tb.sv
// Self-checking testbench for link_reconnect_supervisor_core: drives link polls,
// predicts every result item in lockstep and compares it field by field.
// Depends on lrs_pkg and the core RTL only.
module link_reconnect_supervisor_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lrs_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_MAX    = 10;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;

    link_reconnect_supervisor_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Shadow copy of the configuration registers, starting at their reset values.
    logic [TIME_W-1:0]  cfg_interval     = RETRY_INTERVAL_RST;
    logic [TIME_W-1:0]  cfg_timeout      = ATTEMPT_TIMEOUT_RST;
    logic [TIME_W-1:0]  cfg_cooldown     = COOLDOWN_RST;
    logic [CYCLE_W-1:0] cfg_max_attempts = MAX_ATTEMPTS_RST;

    // Shadow supervisor state; everything clears on reset.
    logic               sup_was_up        = 1'b0;
    logic               sup_pending       = 1'b0;
    logic               sup_cooldown      = 1'b0;
    logic               sup_event         = 1'b0;
    logic [CYCLE_W-1:0] sup_cycle_count   = '0;
    logic [TIME_W-1:0]  sup_last_attempt  = '0;
    logic [TIME_W-1:0]  sup_attempt_start = '0;
    logic [TIME_W-1:0]  sup_cooldown_start = '0;
    logic [COUNT_W-1:0] cnt_disconnect    = '0;
    logic [COUNT_W-1:0] cnt_attempt       = '0;
    logic [COUNT_W-1:0] cnt_success       = '0;
    logic [COUNT_W-1:0] cnt_failure       = '0;

    lrs_result_t        expected_results[$];
    int                 polls_sent      = 0;
    int                 results_checked = 0;
    int                 mismatch_count  = 0;
    int                 settings_used   = 0;
    int                 cooldown_entries = 0;
    int                 cycle_count     = 0;
    bit                 steady          = 1'b0;

    // Stimulus time base and link level for the well-formed poll sequences.
    logic [TIME_W-1:0]  poll_clock = '0;
    logic               link_state = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Computes the result of one poll and advances the shadow state.
    function automatic lrs_result_t predict_poll(input logic [TIME_W-1:0] now,
                                                 input logic up, input logic creds,
                                                 input logic ssid, input logic ack);
        lrs_result_t       res;
        logic [TIME_W-1:0] elapsed;
        logic              go;
        logic              start;
        start = 1'b0;
        // The acknowledge clears the event before anything else happens.
        if (ack) begin
            sup_event = 1'b0;
        end
        if (up) begin
            // Rising edge: fresh retry cycle; a pending attempt counts as recovered.
            if (!sup_was_up) begin
                sup_was_up      = 1'b1;
                sup_cycle_count = '0;
                sup_cooldown    = 1'b0;
                if (sup_pending) begin
                    sup_pending = 1'b0;
                    cnt_success = cnt_success + 1'b1;
                    sup_event   = 1'b1;
                end
            end
        end else begin
            if (sup_was_up) begin
                sup_was_up     = 1'b0;
                cnt_disconnect = cnt_disconnect + 1'b1;
            end
            elapsed = now - sup_attempt_start;
            if (sup_pending && elapsed >= cfg_timeout) begin
                sup_pending = 1'b0;
                cnt_failure = cnt_failure + 1'b1;
            end
            go = creds;
            // An expired cooldown ends and the same poll carries on.
            if (go && sup_cooldown) begin
                elapsed = now - sup_cooldown_start;
                if (elapsed < cfg_cooldown) begin
                    go = 1'b0;
                end else begin
                    sup_cooldown    = 1'b0;
                    sup_cycle_count = '0;
                end
            end
            elapsed = now - sup_last_attempt;
            if (go && elapsed < cfg_interval) begin
                go = 1'b0;
            end
            if (go && sup_cycle_count >= cfg_max_attempts) begin
                sup_cooldown       = 1'b1;
                sup_cooldown_start = now;
                cooldown_entries++;
                go = 1'b0;
            end
            if (go && ssid) begin
                sup_cycle_count   = sup_cycle_count + 1'b1;
                cnt_attempt       = cnt_attempt + 1'b1;
                sup_last_attempt  = now;
                sup_attempt_start = now;
                sup_pending       = 1'b1;
                start             = 1'b1;
            end
        end
        res.connected        = up;
        res.start_reconnect  = start;
        res.recovery_event   = sup_event;
        res.attempt_in_cycle = sup_cycle_count;
        res.in_cooldown      = sup_cooldown;
        res.disconnect_total = cnt_disconnect;
        res.attempt_total    = cnt_attempt;
        res.success_total    = cnt_success;
        res.failure_total    = cnt_failure;
        return res;
    endfunction

    function automatic string describe(input lrs_result_t r);
        return $sformatf({"conn=%0b start=%0b event=%0b cycle=%0d cool=%0b",
                          " disc=%0d att=%0d succ=%0d fail=%0d"},
                         r.connected, r.start_reconnect, r.recovery_event,
                         r.attempt_in_cycle, r.in_cooldown, r.disconnect_total,
                         r.attempt_total, r.success_total, r.failure_total);
    endfunction

    // Sends one poll item, with an occasional idle cycle, and records its expected result.
    task automatic send_poll(input logic [TIME_W-1:0] now, input logic up,
                             input logic creds, input logic ssid, input logic ack);
        if (!steady && $urandom_range(0, 99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, ack, ssid, creds, up, now};
        do @(posedge aclk); while (s_tready !== 1'b1);
        expected_results.push_back(predict_poll(now, up, creds, ssid, ack));
        polls_sent++;
    endtask

    // Lets every outstanding result come back before the configuration changes.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes all four registers one after another; the block must be idle.
    task automatic set_config(input logic [CFG_W-1:0] interval,
                              input logic [CFG_W-1:0] timeout,
                              input logic [CFG_W-1:0] cooldown,
                              input logic [CFG_W-1:0] max_word);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_RETRY_INTERVAL;
        cfg_wdata <= interval;
        @(posedge aclk);
        cfg_index <= REG_ATTEMPT_TIMEOUT;
        cfg_wdata <= timeout;
        @(posedge aclk);
        cfg_index <= REG_COOLDOWN;
        cfg_wdata <= cooldown;
        @(posedge aclk);
        cfg_index <= REG_MAX_ATTEMPTS;
        cfg_wdata <= max_word;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        // Bits above the four-bit attempt limit are dropped by the block.
        cfg_interval     = interval;
        cfg_timeout      = timeout;
        cfg_cooldown     = cooldown;
        cfg_max_attempts = max_word[CYCLE_W-1:0];
        settings_used++;
    endtask

    // Mostly well-formed polls with a forward-moving clock and runs of link up and
    // link down; a small share is pure noise with every field random.
    task automatic run_polls(input int count, input int unsigned step_max);
        logic [TIME_W-1:0] now;
        logic              up;
        logic              creds;
        logic              ssid;
        logic              ack;
        repeat (count) begin
            if ($urandom_range(0, 99) < 5) begin
                now   = $urandom;
                up    = $urandom_range(0, 1);
                creds = $urandom_range(0, 1);
                ssid  = $urandom_range(0, 1);
                ack   = $urandom_range(0, 1);
            end else begin
                if ($urandom_range(0, 99) < (link_state ? 20 : 6)) begin
                    link_state = ~link_state;
                end
                poll_clock = poll_clock + $urandom_range(0, step_max);
                now   = poll_clock;
                up    = link_state;
                creds = $urandom_range(0, 99) < 94;
                ssid  = $urandom_range(0, 99) < 94;
                ack   = $urandom_range(0, 99) < 25;
            end
            send_poll(now, up, creds, ssid, ack);
        end
    endtask

    // Reset values: first attempt after reset, missing credentials or name, timeout,
    // recovery with acknowledge, attempt limit, cooldown expiry and timestamp wrap.
    task automatic test_reset_defaults;
        send_poll(32'd0, 1'b0, 1'b1, 1'b1, 1'b0);
        send_poll(32'd9999, 1'b0, 1'b1, 1'b1, 1'b0);
        send_poll(32'd10000, 1'b0, 1'b1, 1'b0, 1'b0);
        send_poll(32'd10000, 1'b0, 1'b0, 1'b1, 1'b0);
        send_poll(32'd10000, 1'b0, 1'b1, 1'b1, 1'b0);
        send_poll(32'd25000, 1'b0, 1'b1, 1'b1, 1'b0);
        send_poll(32'd26000, 1'b1, 1'b1, 1'b1, 1'b1);
        send_poll(32'd27000, 1'b1, 1'b0, 1'b0, 1'b0);
        send_poll(32'd28000, 1'b0, 1'b1, 1'b1, 1'b1);
        for (int k = 0; k < 6; k++) begin
            send_poll(32'd35000 + k * 10000, 1'b0, 1'b1, 1'b1, 1'b0);
        end
        send_poll(32'd100000, 1'b0, 1'b1, 1'b1, 1'b0);
        send_poll(32'd115000, 1'b0, 1'b1, 1'b1, 1'b0);
        send_poll(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0);
        send_poll(32'd9999, 1'b0, 1'b1, 1'b1, 1'b0);
        send_poll(32'd0, 1'b1, 1'b0, 1'b0, 1'b0);
        drain();
    endtask

    // Short intervals so attempts, timeouts and cooldowns all happen often.
    task automatic test_tight_timing;
        set_config(32'd3, 32'd5, 32'd8, 32'hFFFF_FFF2);
        poll_clock = '0;
        run_polls(150, 4);
        drain();
    endtask

    // A zero attempt limit never starts an attempt; then no spacing at all with
    // the largest limit.
    task automatic test_zero_settings;
        set_config(32'd0, 32'd0, 32'd0, 32'd0);
        run_polls(40, 2);
        drain();
        set_config(32'd0, 32'd0, 32'd0, 32'd15);
        run_polls(60, 1);
        drain();
    endtask

    // All times at their maximum: only an age of all ones reaches them.
    task automatic test_longest_waits;
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd15);
        send_poll(poll_clock, 1'b1, 1'b1, 1'b1, 1'b1);
        send_poll(sup_last_attempt - 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        run_polls(40, 32'hFFFF_FFFF);
        send_poll(sup_attempt_start - 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        drain();
    endtask

    // Random settings; the middle round runs without idling on either side.
    task automatic test_mixed_settings;
        for (int round = 0; round < 3; round++) begin
            set_config($urandom_range(0, 40), $urandom_range(0, 60),
                       $urandom_range(0, 100),
                       ($urandom & 32'hFFFF_FFF0) | $urandom_range(0, 15));
            steady = (round == 1);
            run_polls(70, 25);
            drain();
        end
        steady = 1'b0;
    endtask

    // Reset-value timing again, with the timestamp crossing its wrap point.
    task automatic test_wrapping_defaults;
        set_config(RETRY_INTERVAL_RST, ATTEMPT_TIMEOUT_RST, COOLDOWN_RST, MAX_ATTEMPTS_RST);
        poll_clock = 32'hFFF0_0000;
        run_polls(100, 20000);
        drain();
    endtask

    // Result side stalls at random unless a steady stretch is running.
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 11);
    end

    // Compares each accepted result item against the oldest expectation.
    always @(posedge aclk) begin : result_checker
        lrs_result_t got;
        lrs_result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got.connected        = m_tdata[0];
            got.start_reconnect  = m_tdata[1];
            got.recovery_event   = m_tdata[2];
            got.attempt_in_cycle = m_tdata[6:3];
            got.in_cooldown      = m_tdata[7];
            got.disconnect_total = m_tdata[39:8];
            got.attempt_total    = m_tdata[71:40];
            got.success_total    = m_tdata[103:72];
            got.failure_total    = m_tdata[135:104];
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX) begin
                    $display("Unexpected result item %0d: %s", results_checked, describe(got));
                end
            end else begin
                want = expected_results.pop_front();
                if (got.connected !== want.connected
                        || got.start_reconnect !== want.start_reconnect
                        || got.recovery_event !== want.recovery_event
                        || got.attempt_in_cycle !== want.attempt_in_cycle
                        || got.in_cooldown !== want.in_cooldown
                        || got.disconnect_total !== want.disconnect_total
                        || got.attempt_total !== want.attempt_total
                        || got.success_total !== want.success_total
                        || got.failure_total !== want.failure_total) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("Mismatch on result item %0d", results_checked);
                        $display("  expected %s", describe(want));
                        $display("  actual   %s", describe(got));
                    end
                end
            end
            results_checked++;
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding.",
                     cycle_count, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_tight_timing();
        test_zero_settings();
        test_longest_waits();
        test_mixed_settings();
        test_wrapping_defaults();

        $display("Sent %0d polls over %0d register settings; %0d results checked.",
                 polls_sent, settings_used, results_checked);
        $display({"Covered %0d attempts, %0d recoveries, %0d timeouts,",
                  " %0d link losses, %0d cooldowns."},
                 cnt_attempt, cnt_success, cnt_failure, cnt_disconnect, cooldown_entries);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
